// File: sv/morse_rx_pkg.sv
// Shared types, constants and the pattern decode table for the Morse receiver.
package morse_rx_pkg;

    localparam int THR_W      = 12;
    localparam int TICK_W     = 16;
    localparam int CHAR_W     = 7;
    localparam int PAT_MAX    = 8;
    localparam int CNT_W      = 4;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    localparam logic [THR_W-1:0]  RST_LEVEL_THRESHOLD  = 12'd500;
    localparam logic [TICK_W-1:0] RST_DOT_MIN_TICKS    = 16'd1;
    localparam logic [TICK_W-1:0] RST_DASH_MIN_TICKS   = 16'd3;
    localparam logic [TICK_W-1:0] RST_LETTER_GAP_TICKS = 16'd3;
    localparam logic [TICK_W-1:0] RST_WORD_GAP_TICKS   = 16'd7;
    localparam logic [TICK_W-1:0] RST_END_GAP_TICKS    = 16'd21;

    localparam logic [CHAR_W-1:0] CHAR_NONE    = 7'd0;
    localparam logic [CHAR_W-1:0] CHAR_BLANK   = 7'd32;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'd10;

    typedef enum logic [1:0] {
        MODE_WAITING,
        MODE_MARK,
        MODE_SPACE
    } mode_t;

    typedef enum logic [1:0] {
        SEP_NONE,
        SEP_BLANK,
        SEP_NEWLINE
    } sep_t;

    typedef enum logic [2:0] {
        REG_LEVEL_THRESHOLD,
        REG_DOT_MIN_TICKS,
        REG_DASH_MIN_TICKS,
        REG_LETTER_GAP_TICKS,
        REG_WORD_GAP_TICKS,
        REG_END_GAP_TICKS
    } reg_idx_t;

    typedef struct packed {
        logic [THR_W-1:0]  level_threshold;
        logic [TICK_W-1:0] dot_min_ticks;
        logic [TICK_W-1:0] dash_min_ticks;
        logic [TICK_W-1:0] letter_gap_ticks;
        logic [TICK_W-1:0] word_gap_ticks;
        logic [TICK_W-1:0] end_gap_ticks;
    } cfg_t;

    // One finished letter: its elements (bit i set for a dash) and what follows it.
    typedef struct packed {
        logic [PAT_MAX-1:0] pattern;
        logic [CNT_W-1:0]   count;
        logic               overflow;
        sep_t               sep;
    } event_t;

    function automatic logic [CHAR_W-1:0] decode_pattern(
        input logic [PAT_MAX-1:0] pattern,
        input logic [CNT_W-1:0]   count,
        input logic               overflow
    );
        logic [CHAR_W-1:0] ch;
        ch = CHAR_NONE;
        if (!overflow) begin
            case ({count, pattern})
                {4'd2, 8'b00000010}: ch = 7'h41; // A
                {4'd4, 8'b00000001}: ch = 7'h42; // B
                {4'd4, 8'b00000101}: ch = 7'h43; // C
                {4'd3, 8'b00000001}: ch = 7'h44; // D
                {4'd1, 8'b00000000}: ch = 7'h45; // E
                {4'd4, 8'b00000100}: ch = 7'h46; // F
                {4'd3, 8'b00000011}: ch = 7'h47; // G
                {4'd4, 8'b00000000}: ch = 7'h48; // H
                {4'd2, 8'b00000000}: ch = 7'h49; // I
                {4'd4, 8'b00001110}: ch = 7'h4A; // J
                {4'd3, 8'b00000101}: ch = 7'h4B; // K
                {4'd4, 8'b00000010}: ch = 7'h4C; // L
                {4'd2, 8'b00000011}: ch = 7'h4D; // M
                {4'd2, 8'b00000001}: ch = 7'h4E; // N
                {4'd3, 8'b00000111}: ch = 7'h4F; // O
                {4'd4, 8'b00000110}: ch = 7'h50; // P
                {4'd4, 8'b00001011}: ch = 7'h51; // Q
                {4'd3, 8'b00000010}: ch = 7'h52; // R
                {4'd3, 8'b00000000}: ch = 7'h53; // S
                {4'd1, 8'b00000001}: ch = 7'h54; // T
                {4'd3, 8'b00000100}: ch = 7'h55; // U
                {4'd4, 8'b00001000}: ch = 7'h56; // V
                {4'd3, 8'b00000110}: ch = 7'h57; // W
                {4'd4, 8'b00001001}: ch = 7'h58; // X
                {4'd4, 8'b00001101}: ch = 7'h59; // Y
                {4'd4, 8'b00000011}: ch = 7'h5A; // Z
                {4'd5, 8'b00011110}: ch = 7'h31; // 1
                {4'd5, 8'b00011100}: ch = 7'h32; // 2
                {4'd5, 8'b00011000}: ch = 7'h33; // 3
                {4'd5, 8'b00010000}: ch = 7'h34; // 4
                {4'd5, 8'b00000000}: ch = 7'h35; // 5
                {4'd5, 8'b00000001}: ch = 7'h36; // 6
                {4'd5, 8'b00000011}: ch = 7'h37; // 7
                {4'd5, 8'b00000111}: ch = 7'h38; // 8
                {4'd5, 8'b00001111}: ch = 7'h39; // 9
                {4'd5, 8'b00011111}: ch = 7'h30; // 0
                {4'd6, 8'b00110011}: ch = 7'h2C; // comma
                {4'd6, 8'b00101010}: ch = 7'h2E; // period
                {4'd6, 8'b00001100}: ch = 7'h3F; // question mark
                {4'd5, 8'b00001001}: ch = 7'h2F; // slash
                {4'd6, 8'b00100001}: ch = 7'h2D; // hyphen
                {4'd5, 8'b00001101}: ch = 7'h28; // open paren
                {4'd6, 8'b00101101}: ch = 7'h29; // close paren
                default:             ch = CHAR_NONE;
            endcase
        end
        return ch;
    endfunction

endpackage

// File: sv/morse_rx_regs.sv
// APB-style configuration registers of the Morse receiver.
module morse_rx_regs
    import morse_rx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_LEVEL_THRESHOLD:  cfg_next.level_threshold  = pwdata[THR_W-1:0];
                REG_DOT_MIN_TICKS:    cfg_next.dot_min_ticks    = pwdata[TICK_W-1:0];
                REG_DASH_MIN_TICKS:   cfg_next.dash_min_ticks   = pwdata[TICK_W-1:0];
                REG_LETTER_GAP_TICKS: cfg_next.letter_gap_ticks = pwdata[TICK_W-1:0];
                REG_WORD_GAP_TICKS:   cfg_next.word_gap_ticks   = pwdata[TICK_W-1:0];
                REG_END_GAP_TICKS:    cfg_next.end_gap_ticks    = pwdata[TICK_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_LEVEL_THRESHOLD:  prdata = DATA_W'(cfg_reg.level_threshold);
            REG_DOT_MIN_TICKS:    prdata = DATA_W'(cfg_reg.dot_min_ticks);
            REG_DASH_MIN_TICKS:   prdata = DATA_W'(cfg_reg.dash_min_ticks);
            REG_LETTER_GAP_TICKS: prdata = DATA_W'(cfg_reg.letter_gap_ticks);
            REG_WORD_GAP_TICKS:   prdata = DATA_W'(cfg_reg.word_gap_ticks);
            REG_END_GAP_TICKS:    prdata = DATA_W'(cfg_reg.end_gap_ticks);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level_threshold  <= RST_LEVEL_THRESHOLD;
            cfg_reg.dot_min_ticks    <= RST_DOT_MIN_TICKS;
            cfg_reg.dash_min_ticks   <= RST_DASH_MIN_TICKS;
            cfg_reg.letter_gap_ticks <= RST_LETTER_GAP_TICKS;
            cfg_reg.word_gap_ticks   <= RST_WORD_GAP_TICKS;
            cfg_reg.end_gap_ticks    <= RST_END_GAP_TICKS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: sv/morse_rx_front.sv
// Sample classifier: mark/space state machine, tick counter and element pattern.
module morse_rx_front
    import morse_rx_pkg::*;
#(
    parameter int MAX_ELEMENTS = 6,
    parameter int SAMPLE_BITS  = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   push,
    output logic                   full,
    output event_t                 ev,
    output logic                   ev_push,
    input  logic                   q_full
);

    localparam int CW    = $clog2(MAX_ELEMENTS + 1);
    localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

    mode_t                   mode_reg, mode_next;
    logic [TICK_W-1:0]       tick_reg, tick_next;
    logic [MAX_ELEMENTS-1:0] pat_reg, pat_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    ovf_reg, ovf_next;

    logic                    accept;
    logic [CMP_W-1:0]        s_ext;
    logic [CMP_W-1:0]        thr_ext;
    logic                    above;
    logic                    below;
    logic [TICK_W-1:0]       tick_inc;
    sep_t                    sep;
    logic                    emit;

    assign accept   = push && !q_full;
    assign full     = q_full;
    assign s_ext    = CMP_W'(sample);
    assign thr_ext  = CMP_W'(cfg.level_threshold);
    assign above    = s_ext > thr_ext;
    assign below    = s_ext < thr_ext;
    assign tick_inc = (tick_reg == '1) ? tick_reg : tick_reg + 1'b1;

    assign ev.pattern  = PAT_MAX'(pat_reg);
    assign ev.count    = CNT_W'(cnt_reg);
    assign ev.overflow = ovf_reg;
    assign ev.sep      = sep;
    assign ev_push     = accept && emit;

    always_comb
    begin
        mode_next = mode_reg;
        tick_next = tick_reg;
        pat_next  = pat_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        sep       = SEP_NONE;
        emit      = 1'b0;
        case (mode_reg)
            MODE_MARK:
            begin
                if (below)
                begin
                    if (tick_reg >= cfg.dot_min_ticks || tick_reg >= cfg.dash_min_ticks)
                    begin
                        if (cnt_reg >= CW'(MAX_ELEMENTS))
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            for (int i = 0; i < MAX_ELEMENTS; i++)
                            begin
                                if (cnt_reg == CW'(i) && tick_reg >= cfg.dash_min_ticks)
                                begin
                                    pat_next[i] = 1'b1;
                                end
                            end
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    mode_next = MODE_SPACE;
                    tick_next = '0;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            MODE_SPACE:
            begin
                // end gap wins before the sample is looked at
                if (tick_reg >= cfg.end_gap_ticks)
                begin
                    emit      = 1'b1;
                    sep       = SEP_NEWLINE;
                    mode_next = MODE_WAITING;
                    tick_next = '0;
                end
                else if (above)
                begin
                    if (tick_reg >= cfg.word_gap_ticks)
                    begin
                        emit      = 1'b1;
                        sep       = SEP_BLANK;
                        mode_next = MODE_MARK;
                    end
                    else if (tick_reg >= cfg.letter_gap_ticks)
                    begin
                        emit      = 1'b1;
                        sep       = SEP_NONE;
                        mode_next = MODE_MARK;
                    end
                    else if (tick_reg >= cfg.dot_min_ticks)
                    begin
                        mode_next = MODE_MARK;
                    end
                    tick_next = '0;
                end
                else
                begin
                    tick_next = tick_inc;
                end
                if (emit)
                begin
                    pat_next = '0;
                    cnt_next = '0;
                    ovf_next = 1'b0;
                end
            end
            default:
            begin
                // waiting, and the unused mode code
                mode_next = MODE_WAITING;
                if (above)
                begin
                    mode_next = MODE_MARK;
                    tick_next = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_WAITING;
            tick_reg <= '0;
            pat_reg  <= '0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            tick_reg <= tick_next;
            pat_reg  <= pat_next;
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

// File: sv/morse_rx_queue.sv
// Short event queue between the classifier and the character emitter.
module morse_rx_queue
    import morse_rx_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  event_t wr_data,
    input  logic   wr_en,
    output logic   full,
    output event_t rd_data,
    output logic   empty,
    input  logic   rd_en
);

    event_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_wr;
    logic                do_rd;

    assign full    = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty   = cnt_reg == '0;
    assign rd_data = mem[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: sv/morse_rx_back.sv
// Character emitter: decodes queued letters and delivers characters and separators.
module morse_rx_back
    import morse_rx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  event_t            ev,
    input  logic              q_empty,
    output logic              q_pop,
    output logic [CHAR_W-1:0] character,
    output logic              last,
    output logic              empty,
    input  logic              pop
);

    logic              valid_reg, valid_next;
    sep_t              sep_reg, sep_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;
    logic              load_ok;

    assign load_ok   = !valid_reg || pop;
    assign character = char_reg;
    assign last      = last_reg;
    assign empty     = !valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        sep_next   = sep_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        if (load_ok)
        begin
            valid_next = 1'b0;
            if (sep_reg != SEP_NONE)
            begin
                // separator follows its letter as the final transfer
                valid_next = 1'b1;
                char_next  = (sep_reg == SEP_NEWLINE) ? CHAR_NEWLINE : CHAR_BLANK;
                last_next  = 1'b1;
                sep_next   = SEP_NONE;
            end
            else if (!q_empty)
            begin
                q_pop      = 1'b1;
                valid_next = 1'b1;
                char_next  = decode_pattern(ev.pattern, ev.count, ev.overflow);
                last_next  = ev.sep == SEP_NONE;
                sep_next   = ev.sep;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sep_reg   <= SEP_NONE;
        end
        else
        begin
            valid_reg <= valid_next;
            sep_reg   <= sep_next;
        end
    end

endmodule

// File: sv/morse_code_receiver_core.sv
// Top level of the Morse code receiver: registers, classifier, queue and emitter.
//
//   port group            direction  transfer when
//   sample / push, full   in         push && !full
//   character, last /     out        pop && !empty
//     empty, pop
//   psel .. prdata, pready cfg       psel && penable && pwrite (pready tied high)
//
// One sample is taken every cycle while full is low; the classifier updates its state in the same cycle.
// A finished letter passes through the event queue and the emitter's output register to
// the result ports; a letter with a blank or newline gives two results, the letter first.
// A four-entry event queue parts the two sides; full rises only when it fills
// because results are not being popped. Reset clears control state and loads register defaults.
module morse_code_receiver_core
    import morse_rx_pkg::*;
#(
    parameter int MAX_ELEMENTS = 6,
    parameter int SAMPLE_BITS  = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   push,
    output logic                   full,
    output logic [CHAR_W-1:0]      character,
    output logic                   last,
    output logic                   empty,
    input  logic                   pop,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    cfg_t   cfg;
    event_t fe_ev;
    logic   fe_push;
    event_t q_ev;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;

    morse_rx_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    morse_rx_front #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .sample  (sample),
        .push    (push),
        .full    (full),
        .ev      (fe_ev),
        .ev_push (fe_push),
        .q_full  (q_full)
    );

    morse_rx_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_data (fe_ev),
        .wr_en   (fe_push),
        .full    (q_full),
        .rd_data (q_ev),
        .empty   (q_empty),
        .rd_en   (q_pop)
    );

    morse_rx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev        (q_ev),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .character (character),
        .last      (last),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
